// ----- rtl/glar_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package glar_pkg;

    // Operation of the shared add/subtract unit.
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

`default_nettype wire

// ----- rtl/glar_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface glar_in_if #(
    parameter int VALUE_BITS = 31
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic                  last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/glar_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface glar_out_if #(
    parameter int VALUE_BITS = 31
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] gcd_out;
    logic [VALUE_BITS-1:0] lcm_out;
    logic                  overflow;

    modport source (output valid, output gcd_out, output lcm_out, output overflow,
                    input ready);
    modport sink   (input valid, input gcd_out, input lcm_out, input overflow,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/glar_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none

module glar_alu #(
    parameter int WIDTH = 33
) (
    input  glar_pkg::t_alu_op   i_op,
    input  logic [WIDTH-1:0]    i_a,
    input  logic [WIDTH-1:0]    i_b,
    output logic [WIDTH-1:0]    o_sum
);

    always_comb begin
        case (i_op)
            glar_pkg::ALU_ADD: o_sum = i_a + i_b;
            glar_pkg::ALU_SUB: o_sum = i_a - i_b;
            default:           o_sum = i_a + i_b;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/gcd_lcm_array_reduce.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Running GCD and LCM over a sequence of values, one request per element, the
// final element marked by last. One result request (gcd_out, lcm_out,
// overflow) leaves after each final element; the following element opens a
// new sequence. The LCM saturates at all ones and overflow then stays set for
// the rest of the sequence. The input is accepted only while the sequencer is
// idle; a finished result waits in an output register, so the next element
// may be taken before that result is read. The first element of a sequence
// only seeds the running GCD and LCM. Every later element runs on one shared
// adder/subtractor of VALUE_BITS+2 bits: a binary GCD with the running GCD, a
// second binary GCD with the running LCM, a restoring division and a
// shift-add multiply; the last three are skipped when either the running LCM
// or the new value is zero. A final element also waits until the output
// register is free.
module gcd_lcm_array_reduce #(
    parameter int VALUE_BITS = 31
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    glar_in_if.sink      i_in,
    glar_out_if.source   o_out
);

    localparam int W   = VALUE_BITS;
    localparam int KW  = $clog2(W);
    localparam int AW  = W + 2;

    localparam logic [W-1:0]  VMASK  = {W{1'b1}};
    localparam logic [KW-1:0] CNT_END = KW'(W - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GCD  = 3'd1;
    localparam logic [2:0] ST_SHL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_LCM  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]    r_state, n_state;
    logic          r_inseq, n_inseq;
    logic          r_ovf, n_ovf;
    logic          r_out_valid, n_out_valid;
    logic          r_pass, n_pass;
    logic          r_sat, n_sat;
    logic [KW-1:0] r_k, n_k;
    logic [KW-1:0] r_cnt, n_cnt;

    logic [W-1:0]  r_gcd, n_gcd;
    logic [W-1:0]  r_lcm, n_lcm;
    logic [W-1:0]  r_v, n_v;
    logic          r_last, n_last;
    logic [W-1:0]  r_a, n_a;
    logic [W-1:0]  r_b, n_b;
    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_acc, n_acc;
    logic [W-1:0]  r_out_gcd, n_out_gcd;
    logic [W-1:0]  r_out_lcm, n_out_lcm;
    logic          r_out_ovf, n_out_ovf;

    glar_pkg::t_alu_op alu_op;
    logic [AW-1:0]     alu_a;
    logic [AW-1:0]     alu_b;
    logic [AW-1:0]     alu_sum;
    logic [W:0]        div_part;

    glar_alu #(
        .WIDTH (AW)
    ) u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_sum (alu_sum)
    );

    assign i_in.ready     = (r_state == ST_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.gcd_out  = r_out_gcd;
    assign o_out.lcm_out  = r_out_lcm;
    assign o_out.overflow = r_out_ovf;

    assign div_part = {r_rem, r_quo[W-1]};

    always_comb begin
        n_state     = r_state;
        n_inseq     = r_inseq;
        n_ovf       = r_ovf;
        n_pass      = r_pass;
        n_sat       = r_sat;
        n_k         = r_k;
        n_cnt       = r_cnt;
        n_gcd       = r_gcd;
        n_lcm       = r_lcm;
        n_v         = r_v;
        n_last      = r_last;
        n_a         = r_a;
        n_b         = r_b;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_acc       = r_acc;
        n_out_gcd   = r_out_gcd;
        n_out_lcm   = r_out_lcm;
        n_out_ovf   = r_out_ovf;
        n_out_valid = r_out_valid & ~o_out.ready;

        alu_op = glar_pkg::ALU_SUB;
        alu_a  = {2'b00, r_a};
        alu_b  = {2'b00, r_b};

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_v    = i_in.value;
                    n_last = i_in.last;
                    if (!r_inseq) begin
                        n_gcd   = i_in.value;
                        n_lcm   = i_in.value;
                        n_ovf   = 1'b0;
                        n_inseq = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        n_a     = r_gcd;
                        n_b     = i_in.value;
                        n_k     = '0;
                        n_pass  = 1'b0;
                        n_state = ST_GCD;
                    end
                end
            end

            // One step of the binary GCD; common factors of two are counted in r_k.
            ST_GCD: begin
                if (r_a == '0 || r_b == '0) begin
                    n_a     = r_a | r_b;
                    n_state = ST_SHL;
                end else if (!r_a[0] && !r_b[0]) begin
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_k = r_k + 1'b1;
                end else if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (!alu_sum[AW-1]) begin
                    n_a = alu_sum[W-1:0];
                end else begin
                    // The smaller odd value sits in a; swap and subtract next cycle.
                    n_a = r_b;
                    n_b = r_a;
                end
            end

            ST_SHL: begin
                if (r_k != '0) begin
                    n_a = r_a << 1;
                    n_k = r_k - 1'b1;
                end else if (!r_pass) begin
                    n_gcd = r_a;
                    if (r_lcm == '0 || r_v == '0) begin
                        n_lcm   = '0;
                        n_state = ST_DONE;
                    end else begin
                        n_a     = r_lcm;
                        n_b     = r_v;
                        n_k     = '0;
                        n_pass  = 1'b1;
                        n_state = ST_GCD;
                    end
                end else begin
                    // Divide the running LCM by its GCD with the new value.
                    n_b     = r_a;
                    n_quo   = r_lcm;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end

            ST_DIV: begin
                alu_op = glar_pkg::ALU_SUB;
                alu_a  = {1'b0, div_part};
                alu_b  = {2'b00, r_b};
                if (!alu_sum[AW-1]) begin
                    n_rem = alu_sum[W-1:0];
                end else begin
                    n_rem = div_part[W-1:0];
                end
                n_quo = {r_quo[W-2:0], ~alu_sum[AW-1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_END) begin
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_sat   = 1'b0;
                    n_state = ST_MUL;
                end
            end

            // MSB-first shift-add; the product only matters up to the saturation point.
            ST_MUL: begin
                alu_op = glar_pkg::ALU_ADD;
                alu_a  = {1'b0, r_acc, 1'b0};
                alu_b  = r_quo[W-1] ? {2'b00, r_v} : '0;
                if (!r_sat) begin
                    if (alu_sum[AW-1:W] != 2'b00) begin
                        n_sat = 1'b1;
                    end else begin
                        n_acc = alu_sum[W-1:0];
                    end
                end
                n_quo = {r_quo[W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_END) begin
                    n_state = ST_LCM;
                end
            end

            ST_LCM: begin
                n_lcm   = r_sat ? VMASK : r_acc;
                n_ovf   = r_ovf | r_sat;
                n_state = ST_DONE;
            end

            ST_DONE: begin
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (!r_out_valid || o_out.ready) begin
                    n_out_gcd   = r_gcd;
                    n_out_lcm   = r_lcm;
                    n_out_ovf   = r_ovf;
                    n_out_valid = 1'b1;
                    n_inseq     = 1'b0;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_inseq     <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_pass      <= 1'b0;
            r_sat       <= 1'b0;
            r_k         <= '0;
            r_cnt       <= '0;
            r_gcd       <= '0;
            r_lcm       <= '0;
        end else begin
            r_state     <= n_state;
            r_inseq     <= n_inseq;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            r_pass      <= n_pass;
            r_sat       <= n_sat;
            r_k         <= n_k;
            r_cnt       <= n_cnt;
            r_gcd       <= n_gcd;
            r_lcm       <= n_lcm;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v       <= n_v;
        r_last    <= n_last;
        r_a       <= n_a;
        r_b       <= n_b;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_acc     <= n_acc;
        r_out_gcd <= n_out_gcd;
        r_out_lcm <= n_out_lcm;
        r_out_ovf <= n_out_ovf;
    end

endmodule

`default_nettype wire

// ----- tb/sv/gcd_lcm_array_reduce_tb.sv -----
`timescale 1ns / 1ps

module gcd_lcm_array_reduce_tb;

    localparam int VB = 31;
    localparam logic [VB-1:0] MAXV = '1;
    localparam longint unsigned VMASK = (64'd1 << VB) - 1;
    localparam int LONG_HOLD   = 1500;
    localparam int STALL_LIMIT = 8000;
    localparam int SETTLE      = 400;
    localparam int ITEMS       = 1550;
    localparam int CALM_FROM   = 1350;

    typedef struct packed {
        logic [VB-1:0] gcd;
        logic [VB-1:0] lcm;
        logic          ovf;
    } t_result;

    typedef struct {
        logic [VB-1:0] value;
        bit            last;
        bit            typed;
        t_result       want;
    } t_dir_row;

    localparam t_result NO_RES = '0;

    logic i_clk;
    logic i_rst_n;

    glar_in_if  #(.VALUE_BITS(VB)) req_if ();
    glar_out_if #(.VALUE_BITS(VB)) res_if ();

    gcd_lcm_array_reduce #(
        .VALUE_BITS(VB)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    // Directed rows; expected values are typed in only where they are obvious.
    t_dir_row dir_rows [25] = '{
        '{31'd1,          1'b1, 1'b1, '{31'd1, 31'd1, 1'b0}},
        '{MAXV,           1'b1, 1'b1, '{MAXV, MAXV, 1'b0}},
        '{MAXV,           1'b0, 1'b0, NO_RES},
        '{31'd2,          1'b1, 1'b1, '{31'd1, MAXV, 1'b1}},
        '{31'd46341,      1'b0, 1'b0, NO_RES},
        '{31'd46343,      1'b0, 1'b0, NO_RES},
        '{31'd1,          1'b1, 1'b1, '{31'd1, MAXV, 1'b1}},
        '{MAXV,           1'b0, 1'b0, NO_RES},
        '{MAXV,           1'b1, 1'b1, '{MAXV, MAXV, 1'b0}},
        '{31'd0,          1'b0, 1'b0, NO_RES},
        '{31'd5,          1'b1, 1'b1, '{31'd5, 31'd0, 1'b0}},
        '{31'd7,          1'b0, 1'b0, NO_RES},
        '{31'd0,          1'b1, 1'b1, '{31'd7, 31'd0, 1'b0}},
        '{31'd0,          1'b1, 1'b1, '{31'd0, 31'd0, 1'b0}},
        '{31'd12,         1'b0, 1'b0, NO_RES},
        '{31'd18,         1'b0, 1'b0, NO_RES},
        '{31'd30,         1'b1, 1'b0, NO_RES},
        '{31'h4000_0000,  1'b0, 1'b0, NO_RES},
        '{31'h2000_0000,  1'b0, 1'b0, NO_RES},
        '{31'd3,          1'b1, 1'b0, NO_RES},
        '{31'd1,          1'b0, 1'b0, NO_RES},
        '{31'd1,          1'b0, 1'b0, NO_RES},
        '{31'd1,          1'b1, 1'b0, NO_RES},
        '{31'h5555_5555,  1'b0, 1'b0, NO_RES},
        '{31'h2AAA_AAAA,  1'b1, 1'b0, NO_RES}
    };

    // Running state of the predictor.
    longint unsigned acc_gcd;
    longint unsigned acc_lcm;
    bit              seq_open;
    bit              seq_ovf;

    t_result pending_results [$];
    int      errors;
    int      idle_cycles;
    bit      calm;
    bit      long_hold_pending;
    bit      typed_on;
    t_result typed_res;

    function automatic longint unsigned common_divisor(longint unsigned a, longint unsigned b);
        longint unsigned r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    function automatic longint unsigned clipped_multiple(longint unsigned a, longint unsigned b,
                                                         output bit clipped);
        longint unsigned q;
        clipped = 1'b0;
        if (a == 0 || b == 0) begin
            return 0;
        end
        q = a / common_divisor(a, b);
        if (q > VMASK / b) begin
            clipped = 1'b1;
            return VMASK;
        end
        return q * b;
    endfunction

    function void fold_element(input logic [VB-1:0] v, input bit lst,
                               output bit done, output t_result r);
        longint unsigned x;
        bit              clipped;
        x = v;
        if (!seq_open) begin
            acc_gcd  = x;
            acc_lcm  = x;
            seq_ovf  = 1'b0;
            seq_open = 1'b1;
        end else begin
            acc_gcd = common_divisor(acc_gcd, x);
            acc_lcm = clipped_multiple(acc_lcm, x, clipped);
            if (clipped) begin
                seq_ovf = 1'b1;
            end
        end
        done = lst;
        r    = '{acc_gcd[VB-1:0], acc_lcm[VB-1:0], seq_ovf};
        if (lst) begin
            seq_open = 1'b0;
        end
    endfunction

    // Values are drawn so that sequences often share factors.
    function automatic logic [VB-1:0] pick_value(input int unsigned common);
        longint unsigned m;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: m = longint'(common) * $urandom_range(1, 32'(VMASK / common));
            4, 5:       m = $urandom_range(1, 100);
            6:          m = $urandom_range(1, MAXV);
            7:          m = 64'd1 << $urandom_range(0, VB - 1);
            8:          m = VMASK - $urandom_range(0, 15);
            default:    m = $urandom_range(1, 65535);
        endcase
        return m[VB-1:0];
    endfunction

    task automatic offer(input logic [VB-1:0] v, input bit lst, input bit typed,
                         input t_result want);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        typed_on     = typed;
        typed_res    = want;
        req_if.valid <= 1'b1;
        req_if.value <= v;
        req_if.last  <= lst;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin : monitor
        bit      done;
        bit      moved;
        t_result got;
        t_result exp;
        if (i_rst_n) begin
            moved = 1'b0;
            if (req_if.valid && req_if.ready) begin
                moved = 1'b1;
                fold_element(req_if.value, req_if.last, done, exp);
                if (done) begin
                    pending_results.push_back(typed_on ? typed_res : exp);
                end
            end
            if (res_if.valid && res_if.ready) begin
                moved = 1'b1;
                got = '{res_if.gcd_out, res_if.lcm_out, res_if.overflow};
                if (pending_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected result gcd=%0d lcm=%0d ovf=%0b",
                                 got.gcd, got.lcm, got.ovf);
                    end
                end else begin
                    exp = pending_results.pop_front();
                    if (got.gcd !== exp.gcd || got.lcm !== exp.lcm || got.ovf !== exp.ovf) begin
                        errors++;
                        if (errors <= 10) begin
                            $display({"mismatch: expected gcd=%0d lcm=%0d ovf=%0b,",
                                      " got gcd=%0d lcm=%0d ovf=%0b"},
                                     exp.gcd, exp.lcm, exp.ovf, got.gcd, got.lcm, got.ovf);
                        end
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin : receiver
        int burst;
        res_if.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold_pending) begin
                // Hold results back long enough that the block stalls its input.
                long_hold_pending = 1'b0;
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 3);
                res_if.ready <= 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int          sent;
        int          len;
        int unsigned common;
        bit          held;
        bit          paused;
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.value = '0;
        req_if.last  = 1'b0;
        typed_on     = 1'b0;
        typed_res    = NO_RES;
        errors       = 0;
        idle_cycles  = 0;
        calm         = 1'b0;
        seq_open     = 1'b0;
        seq_ovf      = 1'b0;
        acc_gcd      = 0;
        acc_lcm      = 0;
        held         = 1'b0;
        paused       = 1'b0;
        long_hold_pending = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            offer(dir_rows[i].value, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
        end
        sent = $size(dir_rows);

        while (sent < ITEMS) begin
            if (sent >= CALM_FROM) begin
                calm = 1'b1;
            end
            len    = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
            common = $urandom_range(1, 1 << $urandom_range(0, 20));
            for (int k = 0; k < len; k++) begin
                offer(pick_value(common), k == len - 1, 1'b0, NO_RES);
                sent++;
                if (!held && sent >= 300) begin
                    held = 1'b1;
                    long_hold_pending = 1'b1;
                end
            end
            if (!paused && sent >= 800) begin
                // Let the block drain completely before going on.
                paused = 1'b1;
                @(negedge i_clk);
                req_if.valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
        end

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        errors += pending_results.size();
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
